// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define KWL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer check failed");

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define KWL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer check failed");

`endif

// ===== hdl/kwlex_pkg.sv =====
// Types, codes and decode functions of the keyword token lexer.
`timescale 1ns / 1ps

package kwlex_pkg;

   // Byte position counter width; offsets leave the block as 16 bits.
   localparam int POS_BITS = 16;
   localparam int LEN_BITS = 16;
   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
   localparam int PREFIX_BYTES = 6;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Result kinds
   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Token types
   localparam logic [4:0] TT_PLUS         = 5'd0;
   localparam logic [4:0] TT_MINUS        = 5'd1;
   localparam logic [4:0] TT_DIV          = 5'd2;
   localparam logic [4:0] TT_MULT         = 5'd3;
   localparam logic [4:0] TT_ROUND_OPEN   = 5'd4;
   localparam logic [4:0] TT_ROUND_CLOSE  = 5'd5;
   localparam logic [4:0] TT_CURLY_OPEN   = 5'd6;
   localparam logic [4:0] TT_CURLY_CLOSE  = 5'd7;
   localparam logic [4:0] TT_SQUARE_OPEN  = 5'd8;
   localparam logic [4:0] TT_SQUARE_CLOSE = 5'd9;
   localparam logic [4:0] TT_SEMICOLON    = 5'd10;
   localparam logic [4:0] TT_COMMA        = 5'd11;
   localparam logic [4:0] TT_EQUAL        = 5'd12;
   localparam logic [4:0] TT_DOUBLE_EQUAL = 5'd13;
   localparam logic [4:0] TT_IF           = 5'd14;
   localparam logic [4:0] TT_ELSE         = 5'd15;
   localparam logic [4:0] TT_FN           = 5'd16;
   localparam logic [4:0] TT_LET          = 5'd17;
   localparam logic [4:0] TT_RETURN       = 5'd18;
   localparam logic [4:0] TT_PRINT        = 5'd19;
   localparam logic [4:0] TT_NUMERIC      = 5'd20;
   localparam logic [4:0] TT_IDENT        = 5'd21;

   // Special bytes
   localparam logic [7:0] CH_END     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_EQUALS  = 8'h3d;
   localparam logic [7:0] CH_UNDER   = 8'h5f;

   // Keyword spellings, first byte in the lowest bits, zero padded
   localparam logic [8*PREFIX_BYTES-1:0] KW_IF     = 48'h0000_0000_6669;
   localparam logic [8*PREFIX_BYTES-1:0] KW_ELSE   = 48'h0000_6573_6c65;
   localparam logic [8*PREFIX_BYTES-1:0] KW_FN     = 48'h0000_0000_6e66;
   localparam logic [8*PREFIX_BYTES-1:0] KW_LET    = 48'h0000_0074_656c;
   localparam logic [8*PREFIX_BYTES-1:0] KW_RETURN = 48'h6e72_7574_6572;
   localparam logic [8*PREFIX_BYTES-1:0] KW_PRINT  = 48'h0074_6e69_7270;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  token_code;
      logic [15:0] text_offset;
      logic [15:0] text_length;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
   } punct_info_type;

   function automatic logic is_letter(input logic [7:0] ch);
      return (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a) || ch == CH_UNDER;
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= 8'h30 && ch <= 8'h39;
   endfunction

   function automatic punct_info_type punct_decode(input logic [7:0] ch);
      punct_info_type info;
      info.hit = 1'b1;
      unique case (ch)
         8'h2b:   info.code = TT_PLUS;
         8'h2d:   info.code = TT_MINUS;
         8'h2f:   info.code = TT_DIV;
         8'h2a:   info.code = TT_MULT;
         8'h28:   info.code = TT_ROUND_OPEN;
         8'h29:   info.code = TT_ROUND_CLOSE;
         8'h7b:   info.code = TT_CURLY_OPEN;
         8'h7d:   info.code = TT_CURLY_CLOSE;
         8'h5b:   info.code = TT_SQUARE_OPEN;
         8'h5d:   info.code = TT_SQUARE_CLOSE;
         8'h3b:   info.code = TT_SEMICOLON;
         8'h2c:   info.code = TT_COMMA;
         default: begin
            info.hit  = 1'b0;
            info.code = TT_PLUS;
         end
      endcase
      return info;
   endfunction

   // Bytes past the length are zero, so a whole-prefix compare plus length is enough.
   function automatic logic [4:0] keyword_decode(input logic [8*PREFIX_BYTES-1:0] prefix,
                                                 input logic [LEN_BITS-1:0] len);
      logic [4:0] code;
      code = TT_IDENT;
      if (len == LEN_BITS'(2) && prefix == KW_IF)          code = TT_IF;
      else if (len == LEN_BITS'(4) && prefix == KW_ELSE)   code = TT_ELSE;
      else if (len == LEN_BITS'(2) && prefix == KW_FN)     code = TT_FN;
      else if (len == LEN_BITS'(3) && prefix == KW_LET)    code = TT_LET;
      else if (len == LEN_BITS'(6) && prefix == KW_RETURN) code = TT_RETURN;
      else if (len == LEN_BITS'(5) && prefix == KW_PRINT)  code = TT_PRINT;
      return code;
   endfunction

endpackage

// ===== hdl/keyword_token_lexer.sv =====
// Results of an accepted byte are registered in the result queue, read out in order.
// A byte that closes a pending word or '=' and has a result of its own gives two
// results on consecutive beats.
// Throughput: one byte per cycle while the four-entry result queue has room for two;
// sustained output is one result per ready cycle, set by the single result port.
// Reset: synchronous, active high; clears lexer state, byte position and the queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyword_token_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] token_code, [20:5] text_offset,
                                    // [36:21] text_length, [39:37] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_run
);

   import kwlex_pkg::*;

   // Lexer modes
   localparam logic [1:0] MODE_IDLE = 2'd0;   // between tokens
   localparam logic [1:0] MODE_WORD = 2'd1;   // inside a word
   localparam logic [1:0] MODE_EQ   = 2'd2;   // single '=' pending
   localparam logic [1:0] MODE_SKIP = 2'd3;   // dropping bytes after an error

   // Lexer state
   logic [1:0]                  mode_ff, mode_in;
   logic [POS_BITS-1:0]         start_ff, start_in;
   logic [LEN_BITS-1:0]         len_ff, len_in;
   logic                        saw_ff, saw_in;
   logic [8*PREFIX_BYTES-1:0]   prefix_ff, prefix_in;
   logic [POS_BITS-1:0]         pos_ff, pos_in;

   // Result queue
   rsp_item_type                rsp_queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;

   logic                        req_accept;
   logic                        rsp_pop;
   logic [7:0]                  ch;
   logic                        flush_ready;
   rsp_item_type                flush_item;
   rsp_item_type                main_item;
   rsp_item_type                slot0, slot1;
   logic                        has_flush, has_main;
   logic [1:0]                  push_cnt;
   logic [4:0]                  word_code;
   logic [LEN_BITS-1:0]         base_len;
   logic [8*PREFIX_BYTES-1:0]   base_prefix;
   logic                        base_saw;
   punct_info_type              punct;
   rsp_item_type                head;

   // Take a byte only while two result slots are free, so no result is ever dropped.
   assign req_tready = (count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign ch         = req_tdata;

   // Token left pending by the previous bytes: a word or a single '='.
   always_comb begin
      word_code   = saw_ff ? keyword_decode(prefix_ff, len_ff) : TT_NUMERIC;
      flush_ready = (mode_ff == MODE_WORD) || (mode_ff == MODE_EQ);
      flush_item  = '0;
      flush_item.kind        = KIND_TOKEN;
      flush_item.text_offset = 16'(start_ff);
      if (mode_ff == MODE_WORD) begin
         flush_item.token_code  = word_code;
         flush_item.text_length = (word_code >= TT_NUMERIC) ? 16'(len_ff) : 16'd0;
      end else begin
         flush_item.token_code  = TT_EQUAL;
      end
   end

   // One lexer step per accepted byte: pending flush first, then the byte's own result.
   always_comb begin
      punct       = punct_decode(ch);
      base_len    = (mode_ff == MODE_WORD) ? len_ff : '0;
      base_prefix = (mode_ff == MODE_WORD) ? prefix_ff : '0;
      base_saw    = (mode_ff == MODE_WORD) ? saw_ff : 1'b0;

      has_flush = 1'b0;
      has_main  = 1'b0;
      main_item = '0;
      main_item.text_offset = 16'(pos_ff);

      mode_in   = mode_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      saw_in    = saw_ff;
      prefix_in = prefix_ff;
      pos_in    = pos_ff + POS_BITS'(1);

      if (ch == CH_END) begin
         // Flush unless skipping, report end of text and restart the text.
         has_flush      = flush_ready;
         has_main       = 1'b1;
         main_item.kind = KIND_END;
         mode_in        = MODE_IDLE;
         start_in       = '0;
         len_in         = '0;
         saw_in         = 1'b0;
         prefix_in      = '0;
         pos_in         = '0;
      end else if (mode_ff == MODE_SKIP) begin
         // Drop the byte; only the position advances.
      end else if (is_letter(ch) || is_digit(ch)) begin
         has_flush = (mode_ff == MODE_EQ);
         mode_in   = MODE_WORD;
         if (mode_ff != MODE_WORD) begin
            start_in = pos_ff;
         end
         prefix_in = base_prefix;
         for (int i = 0; i < PREFIX_BYTES; i++) begin
            if (base_len == LEN_BITS'(i)) begin
               prefix_in[8*i +: 8] = ch;
            end
         end
         len_in = (base_len == LEN_MAX) ? base_len : base_len + LEN_BITS'(1);
         saw_in = base_saw || is_letter(ch);
      end else if (ch == CH_EQUALS) begin
         if (mode_ff == MODE_EQ) begin
            has_main               = 1'b1;
            main_item.kind         = KIND_TOKEN;
            main_item.token_code   = TT_DOUBLE_EQUAL;
            main_item.text_offset  = 16'(start_ff);
            mode_in                = MODE_IDLE;
         end else begin
            has_flush = flush_ready;
            mode_in   = MODE_EQ;
            start_in  = pos_ff;
         end
      end else if (ch == CH_SPACE || ch == CH_NEWLINE || ch == CH_TAB) begin
         has_flush = flush_ready;
         mode_in   = MODE_IDLE;
      end else begin
         has_flush = flush_ready;
         has_main  = 1'b1;
         if (punct.hit) begin
            main_item.kind       = KIND_TOKEN;
            main_item.token_code = punct.code;
            mode_in              = MODE_IDLE;
         end else begin
            main_item.kind       = KIND_ERROR;
            mode_in              = MODE_SKIP;
         end
      end

      // Mark the final result of this byte.
      main_item.last_of_run = 1'b1;
      slot0 = has_flush ? flush_item : main_item;
      slot0.last_of_run = !(has_flush && has_main);
      slot1 = main_item;
      push_cnt = 2'(has_flush) + 2'(has_main);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (req_accept) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push_cnt);
      end
      if (rsp_pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      count_in = count_ff + (req_accept ? QUEUE_CNT_BITS'(push_cnt) : '0)
                 - QUEUE_CNT_BITS'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         len_ff    <= '0;
         saw_ff    <= 1'b0;
         prefix_ff <= '0;
         pos_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_accept) begin
            mode_ff   <= mode_in;
            start_ff  <= start_in;
            len_ff    <= len_in;
            saw_ff    <= saw_in;
            prefix_ff <= prefix_in;
            pos_ff    <= pos_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage: write up to two results per transaction, no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept && push_cnt != 2'd0) begin
         rsp_queue_ff[wr_ptr_ff] <= slot0;
      end
      if (req_accept && push_cnt == 2'd2) begin
         rsp_queue_ff[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= slot1;
      end
   end

   // Present the queue head.
   assign head      = rsp_queue_ff[rd_ptr_ff];
   assign rsp_tdata = {3'b000, head.text_length, head.text_offset, head.token_code};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_run;

   // The queue never holds more than its depth.
   `KWL_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
   // An end byte restarts the text at position zero with nothing pending.
   `KWL_ASSERT_NEXT(a_end_restart, clock, reset, req_accept && req_tdata == CH_END,
                    mode_ff == MODE_IDLE && pos_ff == '0)
   // While skipping after an error, ordinary bytes produce no result.
   `KWL_ASSERT_SAME(a_skip_silent, clock, reset,
                    req_accept && mode_ff == MODE_SKIP && req_tdata != CH_END,
                    push_cnt == 2'd0)
   // Taking the only queued result with no new byte leaves the output empty.
   `KWL_ASSERT_NEXT(a_drain_empty, clock, reset,
                    rsp_pop && count_ff == QUEUE_CNT_BITS'(1) && !req_accept, !rsp_tvalid)

endmodule

// ===== sim/tb_keyword_token_lexer.sv =====
// Self-checking testbench for keyword_token_lexer: stream bytes, predict tokens, score results.
`timescale 1ns / 1ps

module tb_keyword_token_lexer;
   import kwlex_pkg::*;

   // Generous ceiling on the number of clock cycles in a run
   localparam int CYCLE_LIMIT = 200_000;
   // Error and end results carry no token type
   localparam logic [4:0] NO_TYPE = 5'd0;
   // Long-word lengths: well past the six-byte keyword prefix
   localparam int LONG_DIGITS = 30;
   localparam int LONG_IDENT  = 25;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_WORD,
      SCAN_EQ,
      SCAN_SKIP
   } scan_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] ch
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [4:0] token_code, [20:5] text_offset,
                                     // [36:21] text_length, [39:37] zero
   logic [1:0]  rsp_tuser;           // [1:0] kind
   logic        rsp_tlast;           // last_of_run

   // Idling enable for both sides; cleared for the long words and the tail
   logic        idle_on = 1'b1;
   int          stall_left = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;

   // Lexer shadow state
   scan_mode_type scan_mode = SCAN_IDLE;
   logic [15:0] tok_start = '0;
   logic [15:0] tok_len = '0;
   logic        tok_has_letter = 1'b0;
   string       tok_head = "";      // first six bytes of the current word
   logic [15:0] text_pos = '0;

   rsp_item_type byte_results[$];        // results caused by the byte in hand
   rsp_item_type pending_lex_results[$]; // results still owed by the block

   string kw_words[6] = '{"if", "else", "fn", "let", "return", "print"};
   string punct_chars = "+-/*(){}[];,";

   keyword_token_lexer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abandon the run if the block stops moving
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL keyword_token_lexer");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Byte classes
   // ------------------------------------------------------------------
   function automatic logic is_alpha_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
   endfunction

   function automatic logic is_digit_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space_char(input logic [7:0] c);
      return c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB;
   endfunction

   // Token type of a single-byte punctuator, or -1 for anything else
   function automatic int punct_code(input logic [7:0] c);
      case (c)
         "+":     return int'(TT_PLUS);
         "-":     return int'(TT_MINUS);
         "/":     return int'(TT_DIV);
         "*":     return int'(TT_MULT);
         "(":     return int'(TT_ROUND_OPEN);
         ")":     return int'(TT_ROUND_CLOSE);
         "{":     return int'(TT_CURLY_OPEN);
         "}":     return int'(TT_CURLY_CLOSE);
         "[":     return int'(TT_SQUARE_OPEN);
         "]":     return int'(TT_SQUARE_CLOSE);
         ";":     return int'(TT_SEMICOLON);
         ",":     return int'(TT_COMMA);
         default: return -1;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Token prediction
   // ------------------------------------------------------------------
   task automatic push_result(input logic [1:0] kind, input logic [4:0] ttype,
                              input logic [15:0] off, input logic [15:0] len);
      rsp_item_type r;
      r.kind        = kind;
      r.token_code  = ttype;
      r.text_offset = off;
      r.text_length = len;
      r.last_of_run = 1'b0;
      byte_results.push_back(r);
   endtask

   // A word is numeric without letters; a keyword only on an exact length match
   function automatic logic [4:0] word_tok_code();
      if (!tok_has_letter)                     return TT_NUMERIC;
      if (tok_len == 16'd2 && tok_head == "if")     return TT_IF;
      if (tok_len == 16'd4 && tok_head == "else")   return TT_ELSE;
      if (tok_len == 16'd2 && tok_head == "fn")     return TT_FN;
      if (tok_len == 16'd3 && tok_head == "let")    return TT_LET;
      if (tok_len == 16'd6 && tok_head == "return") return TT_RETURN;
      if (tok_len == 16'd5 && tok_head == "print")  return TT_PRINT;
      return TT_IDENT;
   endfunction

   // Emit whatever token is pending and drop back to idle
   task automatic close_pending();
      logic [4:0] ttype;
      if (scan_mode == SCAN_WORD) begin
         ttype = word_tok_code();
         push_result(KIND_TOKEN, ttype, tok_start, (ttype >= TT_NUMERIC) ? tok_len : 16'd0);
      end else if (scan_mode == SCAN_EQ) begin
         push_result(KIND_TOKEN, TT_EQUAL, tok_start, 16'd0);
      end
      scan_mode = SCAN_IDLE;
   endtask

   // Advance the shadow lexer by one accepted byte and queue what it owes
   task automatic lex_byte(input logic [7:0] ch);
      int p;
      byte_results.delete();
      p = punct_code(ch);
      if (ch == CH_END) begin
         if (scan_mode != SCAN_SKIP) close_pending();
         push_result(KIND_END, NO_TYPE, text_pos, 16'd0);
         scan_mode      = SCAN_IDLE;
         tok_start      = '0;
         tok_len        = '0;
         tok_has_letter = 1'b0;
         tok_head       = "";
         text_pos       = '0;
      end else begin
         if (scan_mode == SCAN_SKIP) begin
            // swallow everything until the end byte
         end else if (is_alpha_char(ch) || is_digit_char(ch)) begin
            if (scan_mode == SCAN_EQ) close_pending();
            if (scan_mode != SCAN_WORD) begin
               scan_mode      = SCAN_WORD;
               tok_start      = text_pos;
               tok_len        = '0;
               tok_has_letter = 1'b0;
               tok_head       = "";
            end
            if (tok_len < 16'd6) tok_head = $sformatf("%s%c", tok_head, ch);
            if (tok_len != LEN_MAX) tok_len = tok_len + 16'd1;
            if (is_alpha_char(ch)) tok_has_letter = 1'b1;
         end else if (ch == CH_EQUALS) begin
            if (scan_mode == SCAN_EQ) begin
               push_result(KIND_TOKEN, TT_DOUBLE_EQUAL, tok_start, 16'd0);
               scan_mode = SCAN_IDLE;
            end else begin
               close_pending();
               scan_mode = SCAN_EQ;
               tok_start = text_pos;
            end
         end else if (is_space_char(ch)) begin
            close_pending();
         end else begin
            close_pending();
            if (p >= 0) begin
               push_result(KIND_TOKEN, 5'(p), text_pos, 16'd0);
            end else begin
               push_result(KIND_ERROR, NO_TYPE, text_pos, 16'd0);
               scan_mode = SCAN_SKIP;
            end
         end
         text_pos = text_pos + 16'd1;
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_of_run = 1'b1;
      foreach (byte_results[i]) pending_lex_results.push_back(byte_results[i]);
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure and scoring
   // ------------------------------------------------------------------
   // Random stall bursts; stall_left counts the cycles still to hold
   always @(posedge clock) begin
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else if (idle_on && stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest owed result
   always @(posedge clock) begin : score_results
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind        = rsp_tuser;
         seen.token_code  = rsp_tdata[4:0];
         seen.text_offset = rsp_tdata[20:5];
         seen.text_length = rsp_tdata[36:21];
         seen.last_of_run = rsp_tlast;
         if (pending_lex_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, got kind=%0d type=%0d off=%0d len=%0d last=%0b",
                     $realtime, seen.kind, seen.token_code, seen.text_offset,
                     seen.text_length, seen.last_of_run);
         end else begin
            want = pending_lex_results.pop_front();
            if (seen !== want) begin
               fail_count++;
               $display("%0t: mismatch, expected kind=%0d type=%0d off=%0d len=%0d last=%0b, got kind=%0d type=%0d off=%0d len=%0d last=%0b",
                        $realtime, want.kind, want.token_code, want.text_offset,
                        want.text_length, want.last_of_run, seen.kind, seen.token_code,
                        seen.text_offset, seen.text_length, seen.last_of_run);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Byte side
   // ------------------------------------------------------------------
   // Offer one byte, hold it until the handshake, then maybe idle for a burst
   task automatic send_byte(input logic [7:0] ch);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lex_byte(ch);
      bytes_sent++;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_word(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic send_text(input string s);
      send_word(s);
      send_byte(CH_END);
   endtask

   // Hold off the sender until the block has delivered everything owed
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_lex_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_word_byte(input logic leading);
      int pick;
      pick = $urandom_range(0, leading ? 52 : 62);
      if (pick < 26) return 8'("a") + 8'(pick);
      if (pick < 52) return 8'("A") + 8'(pick - 26);
      if (pick == 52) return CH_UNDER;
      return 8'("0") + 8'(pick - 53);
   endfunction

   function automatic logic [7:0] rand_space();
      case ($urandom_range(0, 2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_NEWLINE;
      endcase
   endfunction

   // Any non-zero byte that is not part of the token alphabet, high bytes included
   function automatic logic [7:0] rand_error_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(1, 255));
      end while (is_alpha_char(b) || is_digit_char(b) || is_space_char(b) ||
                 b == CH_EQUALS || punct_code(b) >= 0);
      return b;
   endfunction

   // Mostly well-formed token streams with random content; one text in ten is raw noise
   task automatic send_random_text();
      int n_tok;
      int len;
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(1, 16);
         repeat (len) send_byte(8'($urandom_range(1, 255)));
      end else begin
         n_tok = $urandom_range(1, 12);
         repeat (n_tok) begin
            case ($urandom_range(0, 9))
               0: send_word(kw_words[$urandom_range(0, 5)]);
               1, 2: begin
                  send_byte(rand_word_byte(1'b1));
                  len = $urandom_range(0, 8);
                  repeat (len) send_byte(rand_word_byte(1'b0));
               end
               3: begin
                  len = $urandom_range(1, 6);
                  repeat (len) send_byte(8'("0") + 8'($urandom_range(0, 9)));
               end
               4, 5: send_byte(punct_chars[$urandom_range(0, 11)]);
               6: send_byte(CH_EQUALS);
               7: begin
                  send_byte(CH_EQUALS);
                  send_byte(CH_EQUALS);
               end
               8: send_byte(rand_space());
               default: begin
                  if ($urandom_range(0, 3) == 0) send_byte(rand_error_byte());
                  else send_byte(rand_space());
               end
            endcase
            // Leave tokens abutting about half the time so flushes pair up
            if ($urandom_range(0, 1) == 0) send_byte(rand_space());
         end
      end
      send_byte(CH_END);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_empty_text();
      send_byte(CH_END);
   endtask

   task automatic test_punctuation();
      send_text("+-/*(){}[];,\t\n ");
   endtask

   // Lone '=', '==' over a word boundary, '===' and '=' flushed by the end byte
   task automatic test_equals();
      send_text("=a== ===;=");
   endtask

   // Every keyword, near misses, numerics, and a word flushed by the end byte
   task automatic test_keywords();
      send_text("if else fn let return print iff returns _ 09 9z");
      send_text("retur");
   endtask

   // Word closed by an error, skipped bytes, high bytes and a pending '=' before an error
   task automatic test_errors();
      send_text("ab!cd +");
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(CH_END);
      send_text("=$");
   endtask

   // Words past the six-byte prefix: never keywords, full length still counted
   task automatic test_long_words();
      idle_on <= 1'b0;
      repeat (LONG_DIGITS) send_byte(8'("0") + 8'($urandom_range(0, 9)));
      send_byte(CH_SPACE);
      send_word("returnx");
      send_byte(CH_SPACE);
      send_byte("q");
      repeat (LONG_IDENT - 1) send_byte(rand_word_byte(1'b0));
      send_byte(CH_EQUALS);
      send_byte(CH_END);
      idle_on <= 1'b1;
   endtask

   // Pause mid-text with '=' pending, then finish the '=='
   task automatic test_drain_pause();
      send_word("a;b=");
      drain_results();
      send_text("=c");
   endtask

   task automatic test_random_texts(input int byte_budget);
      int first;
      first = bytes_sent;
      while (bytes_sent - first < byte_budget) send_random_text();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_text();
      test_punctuation();
      test_equals();
      test_keywords();
      test_errors();
      test_long_words();
      test_random_texts(500);
      test_drain_pause();
      test_random_texts(450);

      // Final stretch at full rate on both sides
      idle_on <= 1'b0;
      test_random_texts(250);

      req_tvalid <= 1'b0;
      while (pending_lex_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS keyword_token_lexer");
      end else begin
         $display("FAIL keyword_token_lexer");
      end
      $finish;
   end

endmodule
